// ===== hdl/tcc_pkg.sv =====
// Shared constants, types and the arctangent table for the tilt compensated compass.
// No dependencies.
package tcc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    // CORDIC vector datapath width and normalization target bit
    localparam int VEC_W            = 48;
    localparam int NORM_BIT         = 40;
    localparam int NORM_STAGES      = 6;
    // angle width: degrees scaled by 2^16
    localparam int Z_W              = 27;
    // sin/cos width, Q16
    localparam int ROT_W            = 20;
    localparam int INV_GAIN         = 39797;
    localparam int DEG180           = 180 * 65536;
    localparam int PITCH_W          = 14;
    localparam int HEAD_W           = 15;
    localparam int PITCH_LIM        = 5760;
    localparam int HEAD_LIM         = 11520;

    typedef logic signed [Z_W-1:0] t_angle;

    // round(atan(2^-i) in degrees * 2^16)
    function automatic t_angle atan_entry(input int idx);
        t_angle v;
        case (idx)
            0:  v = t_angle'(2949120);
            1:  v = t_angle'(1740967);
            2:  v = t_angle'(919879);
            3:  v = t_angle'(466945);
            4:  v = t_angle'(234379);
            5:  v = t_angle'(117304);
            6:  v = t_angle'(58666);
            7:  v = t_angle'(29335);
            8:  v = t_angle'(14668);
            9:  v = t_angle'(7334);
            10: v = t_angle'(3667);
            11: v = t_angle'(1833);
            12: v = t_angle'(917);
            13: v = t_angle'(458);
            14: v = t_angle'(229);
            15: v = t_angle'(115);
            16: v = t_angle'(57);
            17: v = t_angle'(29);
            18: v = t_angle'(14);
            19: v = t_angle'(7);
            20: v = t_angle'(4);
            21: v = t_angle'(2);
            22: v = t_angle'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // number of micro-rotations actually used
    function automatic int steps_of(input int s);
        return (s < ATAN_LEN) ? s : ATAN_LEN;
    endfunction

endpackage

// ===== hdl/tcc_delay.sv =====
// Enabled shift line that carries a payload through a fixed number of stages.
// Depends on nothing.
module tcc_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [D];

    // first tap
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
        end
    end

    // remaining taps
    genvar k;
    generate
        for (k = 1; k < D; k++) begin : g_tap
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_line[k] <= r_line[k-1];
                end
            end
        end
    endgenerate

    assign o_q = r_line[D-1];

endmodule

// ===== hdl/tcc_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
// Depends on nothing.
module tcc_isqrt #(
    parameter int RW = 24
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_n,
    output logic [RW-1:0]   o_root
);

    localparam int RMW = RW + 2;

    logic [2*RW-1:0] r_n    [RW];
    logic [RMW-1:0]  r_rem  [RW];
    logic [RW-1:0]   r_root [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++) begin : g_stage
            logic [2*RW-1:0] pn;
            logic [RMW-1:0]  prem;
            logic [RW-1:0]   proot;
            logic [RMW-1:0]  rem_sh;
            logic [RMW-1:0]  trial;

            if (k == 0) begin : g_first
                assign pn    = i_n;
                assign prem  = '0;
                assign proot = '0;
            end else begin : g_next
                assign pn    = r_n[k-1];
                assign prem  = r_rem[k-1];
                assign proot = r_root[k-1];
            end

            // bring down the next bit pair, try root*4+1
            assign rem_sh = {prem[RMW-3:0], pn[2*RW-1:2*RW-2]};
            assign trial  = {proot, 2'b01};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[k] <= {pn[2*RW-3:0], 2'b00};
                    if (rem_sh >= trial) begin
                        r_rem[k]  <= rem_sh - trial;
                        r_root[k] <= {proot[RW-2:0], 1'b1};
                    end else begin
                        r_rem[k]  <= rem_sh;
                        r_root[k] <= {proot[RW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[RW-1];

endmodule

// ===== hdl/tcc_vector.sv =====
// Pipelined CORDIC vectoring: half-plane fold, normalize shift, micro-rotations -> atan2(y, x).
// Depends on tcc_pkg.
module tcc_vector
    import tcc_pkg::*;
#(
    parameter int NST = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [VEC_W-1:0] i_x,
    input  logic signed [VEC_W-1:0] i_y,
    output t_angle                  o_z
);

    localparam int NS = NST + NORM_STAGES + 1;

    logic signed [VEC_W-1:0] r_x    [NS];
    logic signed [VEC_W-1:0] r_y    [NS];
    t_angle                  r_z    [NS];
    logic                    r_zero [NS];

    // fold left half plane onto the right, preload +-180
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[VEC_W-1]) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= i_y[VEC_W-1] ? -t_angle'(DEG180) : t_angle'(DEG180);
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    genvar j, i;
    generate
        // normalize: binary search for the shift that brings the magnitude to bit NORM_BIT
        for (j = 0; j < NORM_STAGES; j++) begin : g_norm
            localparam int SH = 1 << (NORM_STAGES - 1 - j);
            logic signed [VEC_W-1:0] ay;
            logic [VEC_W-1:0]        mag;
            logic                    fits;

            assign ay   = r_y[j][VEC_W-1] ? -r_y[j] : r_y[j];
            assign mag  = r_x[j] | ay;
            assign fits = (mag >> (NORM_BIT + 1 - SH)) == '0;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[j+1]    <= fits ? (r_x[j] <<< SH) : r_x[j];
                    r_y[j+1]    <= fits ? (r_y[j] <<< SH) : r_y[j];
                    r_z[j+1]    <= r_z[j];
                    r_zero[j+1] <= r_zero[j];
                end
            end
        end

        // micro-rotations driving y toward zero
        for (i = 0; i < NST; i++) begin : g_rot
            localparam int S = NORM_STAGES + i;
            logic signed [VEC_W-1:0] dx;
            logic signed [VEC_W-1:0] dy;

            assign dx = r_y[S] >>> i;
            assign dy = r_x[S] >>> i;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_zero[S+1] <= r_zero[S];
                    if (!r_y[S][VEC_W-1]) begin
                        r_x[S+1] <= r_x[S] + dx;
                        r_y[S+1] <= r_y[S] - dy;
                        r_z[S+1] <= r_z[S] + atan_entry(i);
                    end else begin
                        r_x[S+1] <= r_x[S] - dx;
                        r_y[S+1] <= r_y[S] + dy;
                        r_z[S+1] <= r_z[S] - atan_entry(i);
                    end
                end
            end
        end
    endgenerate

    // zero vector reads as angle zero
    assign o_z = r_zero[NS-1] ? '0 : r_z[NS-1];

endmodule

// ===== hdl/tcc_rotate.sv =====
// Pipelined CORDIC rotation giving cos and sin of an angle in Q16.
// Depends on tcc_pkg.
module tcc_rotate
    import tcc_pkg::*;
#(
    parameter int NST = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  t_angle                  i_z,
    output logic signed [ROT_W-1:0] o_cos,
    output logic signed [ROT_W-1:0] o_sin
);

    logic signed [ROT_W-1:0] r_x [NST];
    logic signed [ROT_W-1:0] r_y [NST];
    t_angle                  r_z [NST];

    genvar i;
    generate
        for (i = 0; i < NST; i++) begin : g_stage
            logic signed [ROT_W-1:0] px;
            logic signed [ROT_W-1:0] py;
            t_angle                  pz;
            logic signed [ROT_W-1:0] dx;
            logic signed [ROT_W-1:0] dy;

            // start from the gain-corrected unit vector
            if (i == 0) begin : g_first
                assign px = ROT_W'(INV_GAIN);
                assign py = '0;
                assign pz = i_z;
            end else begin : g_next
                assign px = r_x[i-1];
                assign py = r_y[i-1];
                assign pz = r_z[i-1];
            end

            assign dx = py >>> i;
            assign dy = px >>> i;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!pz[Z_W-1]) begin
                        r_x[i] <= px - dx;
                        r_y[i] <= py + dy;
                        r_z[i] <= pz - atan_entry(i);
                    end else begin
                        r_x[i] <= px + dx;
                        r_y[i] <= py - dy;
                        r_z[i] <= pz + atan_entry(i);
                    end
                end
            end
        end
    endgenerate

    assign o_cos = r_x[NST-1];
    assign o_sin = r_y[NST-1];

endmodule

// ===== hdl/tilt_compensated_compass.sv =====
// Tilt compensated compass: pitch, roll and heading from accelerometer and magnetometer beats.
// Pipeline: squares, radicands, square roots, pitch/roll vectoring, sin/cos rotation, products,
//   heading vectoring, output register; RW = SAMPLE_WIDTH+8, NST = min(CORDIC_STEPS,24), LV = NST+7.
// Throughput: one beat per cycle; the whole pipeline holds only while the output is stalled.
// Reset (synchronous, active low) clears the valid bits; no other state.
// Depends on tcc_pkg, tcc_delay, tcc_isqrt, tcc_vector, tcc_rotate.
module tilt_compensated_compass
    import tcc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z (low bits first)
    input  logic [((6*SAMPLE_WIDTH+7)/8)*8-1:0]         i_s_tdata,
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // pitch_deg, roll_deg, heading_deg (low bits first)
    output logic [((2*PITCH_W+HEAD_W+7)/8)*8-1:0]       o_m_tdata
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int SQ_W  = 2*SW;
    localparam int NST   = steps_of(CORDIC_STEPS);
    localparam int RW    = SW + 8;
    localparam int LV    = NST + NORM_STAGES + 1;
    localparam int OUT_W = ((2*PITCH_W+HEAD_W+7)/8)*8;
    localparam int PW    = SW + ROT_W;
    localparam int T_W   = 2*ROT_W - 16;
    localparam int MW    = SW + T_W;
    localparam int TOT   = 2 + RW + LV + NST + 4 + LV + 1;

    logic en;
    logic [TOT-1:0] r_valid;

    // global advance: move unless the output beat is held
    assign en         = !r_valid[TOT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_valid[TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[TOT-2:0], i_s_tvalid};
        end
    end

    // unpack input beat
    logic signed [SW-1:0] ax, ay, az;
    assign ax = i_s_tdata[0*SW +: SW];
    assign ay = i_s_tdata[1*SW +: SW];
    assign az = i_s_tdata[2*SW +: SW];

    // squares, full width
    logic [2*SW-1:0] r_sx, r_sy, r_sz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx <= $unsigned(SQ_W'(ax) * SQ_W'(ax));
            r_sy <= $unsigned(SQ_W'(ay) * SQ_W'(ay));
            r_sz <= $unsigned(SQ_W'(az) * SQ_W'(az));
        end
    end

    // radicands scaled by 2^16
    logic [2*RW-1:0] r_rad_p, r_rad_r;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad_p <= {r_sy + r_sz, 16'b0};
            r_rad_r <= {r_sx + r_sz, 16'b0};
        end
    end

    logic [RW-1:0] root_p, root_r;
    tcc_isqrt #(.RW(RW)) u_sqrt_p (.i_clk(i_clk), .i_en(en), .i_n(r_rad_p), .o_root(root_p));
    tcc_isqrt #(.RW(RW)) u_sqrt_r (.i_clk(i_clk), .i_en(en), .i_n(r_rad_r), .o_root(root_r));

    // accel x/y aligned with the roots
    logic [2*SW-1:0] axy_d;
    tcc_delay #(.W(2*SW), .D(2+RW)) u_dly_acc (
        .i_clk(i_clk), .i_en(en), .i_d({ay, ax}), .o_q(axy_d)
    );

    logic signed [VEC_W-1:0] num_p, num_r, den_p, den_r;
    assign num_p = VEC_W'($signed(axy_d[SW-1:0])) <<< 8;
    assign num_r = VEC_W'($signed(axy_d[2*SW-1:SW])) <<< 8;
    assign den_p = $signed({{(VEC_W-RW){1'b0}}, root_p});
    assign den_r = $signed({{(VEC_W-RW){1'b0}}, root_r});

    t_angle zp, zr;
    tcc_vector #(.NST(NST)) u_vec_p (.i_clk(i_clk), .i_en(en), .i_x(den_p), .i_y(num_p), .o_z(zp));
    tcc_vector #(.NST(NST)) u_vec_r (.i_clk(i_clk), .i_en(en), .i_x(den_r), .i_y(num_r), .o_z(zr));

    logic signed [ROT_W-1:0] cp, sp, cr, sr;
    tcc_rotate #(.NST(NST)) u_rot_p (.i_clk(i_clk), .i_en(en), .i_z(zp), .o_cos(cp), .o_sin(sp));
    tcc_rotate #(.NST(NST)) u_rot_r (.i_clk(i_clk), .i_en(en), .i_z(zr), .o_cos(cr), .o_sin(sr));

    // magnetometer aligned with sin/cos
    logic [3*SW-1:0] mag_d;
    tcc_delay #(.W(3*SW), .D(2+RW+LV+NST)) u_dly_mag (
        .i_clk(i_clk), .i_en(en), .i_d(i_s_tdata[3*SW +: 3*SW]), .o_q(mag_d)
    );

    logic signed [SW-1:0] mx, my, mz;
    assign mx = mag_d[0*SW +: SW];
    assign my = mag_d[1*SW +: SW];
    assign mz = mag_d[2*SW +: SW];

    // product stage 1: first-level products
    logic signed [PW-1:0]      r_hxa, r_hxb, r_mycr1;
    logic signed [2*ROT_W-1:0] r_srsp, r_srcp;
    logic signed [SW-1:0]      r_mx1, r_mz1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hxa   <= mx * cp;
            r_hxb   <= mz * sp;
            r_mycr1 <= my * cr;
            r_srsp  <= sr * sp;
            r_srcp  <= sr * cp;
            r_mx1   <= mx;
            r_mz1   <= mz;
        end
    end

    // product stage 2: back to Q16, hx sum
    logic signed [T_W-1:0]   r_t1, r_t2;
    logic signed [VEC_W-1:0] r_hx2;
    logic signed [PW-1:0]    r_mycr2;
    logic signed [SW-1:0]    r_mx2, r_mz2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1    <= T_W'(r_srsp >>> 16);
            r_t2    <= T_W'(r_srcp >>> 16);
            r_hx2   <= VEC_W'(r_hxa) + VEC_W'(r_hxb);
            r_mycr2 <= r_mycr1;
            r_mx2   <= r_mx1;
            r_mz2   <= r_mz1;
        end
    end

    // product stage 3: cross terms
    logic signed [MW-1:0]    r_m1, r_m3;
    logic signed [PW-1:0]    r_mycr3;
    logic signed [VEC_W-1:0] r_hx3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1    <= r_mx2 * r_t1;
            r_m3    <= r_mz2 * r_t2;
            r_mycr3 <= r_mycr2;
            r_hx3   <= r_hx2;
        end
    end

    // product stage 4: hy sum
    logic signed [VEC_W-1:0] r_hx4, r_hy4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hx4 <= r_hx3;
            r_hy4 <= VEC_W'(r_m1) + VEC_W'(r_mycr3) - VEC_W'(r_m3);
        end
    end

    t_angle zh;
    tcc_vector #(.NST(NST)) u_vec_h (.i_clk(i_clk), .i_en(en), .i_x(r_hx4), .i_y(r_hy4), .o_z(zh));

    // pitch/roll aligned with heading
    logic [2*Z_W-1:0] pr_d;
    tcc_delay #(.W(2*Z_W), .D(NST+4+LV)) u_dly_pr (
        .i_clk(i_clk), .i_en(en), .i_d({zr, zp}), .o_q(pr_d)
    );

    // round to 1/64 degree and saturate
    function automatic logic signed [HEAD_W-1:0] to_out(input t_angle z, input int lim);
        t_angle q;
        q = (z + t_angle'(512)) >>> 10;
        if (q > lim) begin
            q = t_angle'(lim);
        end else if (q < -lim) begin
            q = t_angle'(-lim);
        end
        return HEAD_W'(q);
    endfunction

    logic signed [HEAD_W-1:0] pitch_w, roll_w, head_w;
    assign pitch_w = to_out(pr_d[Z_W-1:0], PITCH_LIM);
    assign roll_w  = to_out(pr_d[2*Z_W-1:Z_W], PITCH_LIM);
    assign head_w  = to_out(zh, HEAD_LIM);

    // output register
    logic [PITCH_W-1:0] r_pitch, r_roll;
    logic [HEAD_W-1:0]  r_head;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pitch <= pitch_w[PITCH_W-1:0];
            r_roll  <= roll_w[PITCH_W-1:0];
            r_head  <= head_w;
        end
    end

    assign o_m_tdata = {{(OUT_W-2*PITCH_W-HEAD_W){1'b0}}, r_head, r_roll, r_pitch};

endmodule
